[hdl/apr_pkg.sv]
// apr_pkg: shared types and constants for the aging page-replacement unit.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package apr_pkg;

	// Field widths
	localparam int AGE_W        = 32;
	localparam int FRAME_W      = 6;
	localparam int PAGE_FIELD_W = 6;
	localparam int COUNT_W      = 7;

	// Frame allocation limits
	localparam logic [COUNT_W-1:0] MAX_FRAMES      = 7'd64;
	localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 7'd16;

	// Configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_FRAME_COUNT = 2'd0;

	// Operation codes
	typedef enum logic [1:0] {
		OP_REF   = 2'd0,
		OP_REQ   = 2'd1,
		OP_MAP   = 2'd2,
		OP_UNMAP = 2'd3
	} op_t;

	// One page-table entry as stored in the table memory
	typedef struct packed {
		logic [AGE_W-1:0]   age;
		logic               present;
		logic               referenced;
		logic [FRAME_W-1:0] frame;
	} entry_t;

	// One result transaction
	typedef struct packed {
		logic [FRAME_W-1:0]      granted_frame;
		logic [PAGE_FIELD_W-1:0] victim_page;
		logic                    evicted;
	} res_t;

endpackage

[hdl/apr_ifs.sv]
// apr_ifs: valid/ready channel interfaces for commands and results.
// Depends on apr_pkg for field widths.
interface apr_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       opcode;
	logic [apr_pkg::PAGE_FIELD_W-1:0] page;
	logic [apr_pkg::FRAME_W-1:0]      frame;

	modport source (output valid, opcode, page, frame, input ready);
	modport sink   (input valid, opcode, page, frame, output ready);
endinterface

interface apr_res_if;
	logic                             valid;
	logic                             ready;
	logic [apr_pkg::FRAME_W-1:0]      granted_frame;
	logic [apr_pkg::PAGE_FIELD_W-1:0] victim_page;
	logic                             evicted;

	modport source (output valid, granted_frame, victim_page, evicted, input ready);
	modport sink   (input valid, granted_frame, victim_page, evicted, output ready);
endinterface

[hdl/aging_page_replacement.sv]
// aging_page_replacement: top level of the aging page-replacement unit.
// Depends on apr_pkg, apr_ifs, apr_cfg, apr_mem and apr_ctrl.
//
// Aging page-replacement unit for PAGE_COUNT virtual pages. Each page's age,
// present bit, referenced bit and frame number live in one page-table memory
// with a single read and a single write port. After reset the unit clears that
// memory, one entry per cycle, before it takes the first command transaction;
// frame_count may be written during that time. Commands are taken one at a
// time. Reference, map and unmap go from acceptance through a memory read, a
// write back and the result register; a request served from a free frame
// needs no memory access. A request that has to replace a page walks the page
// table through the read port, one entry per cycle, aging each present page
// and tracking the minimum. A finished result sits in an output register, so
// a new command is accepted while the previous result still waits to be taken.
module aging_page_replacement #(
	parameter int PAGE_COUNT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [apr_pkg::PADDR_W-1:0]   paddr,
	input  logic [apr_pkg::PDATA_W-1:0]   pwdata,
	output logic [apr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	apr_cmd_if.sink                       cmd,
	apr_res_if.source                     res
);

	localparam int AW = $clog2(PAGE_COUNT);

	logic [apr_pkg::COUNT_W-1:0] frame_count;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	apr_pkg::entry_t             mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	apr_pkg::entry_t             mem_rdata;

	// configuration registers
	apr_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_count (frame_count)
	);

	// page-table memory
	apr_mem #(
		.DEPTH (PAGE_COUNT)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer
	apr_ctrl #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_count (frame_count),
		.cmd         (cmd),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

endmodule

[hdl/apr_cfg.sv]
// apr_cfg: APB-style register block holding frame_count.
// Depends on apr_pkg for address map and widths.
module apr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [apr_pkg::PADDR_W-1:0]   paddr,
	input  logic [apr_pkg::PDATA_W-1:0]   pwdata,
	output logic [apr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [apr_pkg::COUNT_W-1:0]   frame_count
);

	logic [apr_pkg::COUNT_W-1:0] frame_count_q;
	logic                        wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr == apr_pkg::ADDR_FRAME_COUNT);

	// frame_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= apr_pkg::FRAME_COUNT_RST;
		end else if (wr_hit) begin
			frame_count_q <= pwdata[apr_pkg::COUNT_W-1:0];
		end
	end

	// read mux
	always_comb begin
		if (paddr == apr_pkg::ADDR_FRAME_COUNT) begin
			prdata = apr_pkg::PDATA_W'(frame_count_q);
		end else begin
			prdata = '0;
		end
	end

	assign frame_count = frame_count_q;

endmodule

[hdl/apr_mem.sv]
// apr_mem: page-table memory, one write port and one read port, registered read.
// Depends on apr_pkg for the entry type.
module apr_mem #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  apr_pkg::entry_t          wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output apr_pkg::entry_t          rdata
);

	apr_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/apr_ctrl.sv]
// apr_ctrl: sequencer for the page table: clearing pass, read-modify-write
// updates, free-frame grants, aging sweep with running minimum, result register.
// Depends on apr_pkg and the channel interfaces in apr_ifs.
module apr_ctrl #(
	parameter int PAGE_COUNT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [apr_pkg::COUNT_W-1:0]     frame_count,
	apr_cmd_if.sink                         cmd,
	apr_res_if.source                       res,
	output logic                            mem_we,
	output logic [$clog2(PAGE_COUNT)-1:0]   mem_waddr,
	output apr_pkg::entry_t                 mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(PAGE_COUNT)-1:0]   mem_raddr,
	input  apr_pkg::entry_t                 mem_rdata
);

	localparam int AW = $clog2(PAGE_COUNT);
	localparam logic [AW-1:0] LAST = AW'(PAGE_COUNT - 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RMW   = 7'b0000100,
		ST_SWEEP = 7'b0001000,
		ST_FIX   = 7'b0010000,
		ST_DONE  = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	state_t                        state_q;
	apr_pkg::op_t                  op_q;
	apr_pkg::op_t                  cmd_op;
	logic [AW-1:0]                 page_q;
	logic [apr_pkg::FRAME_W-1:0]   frame_q;
	logic [AW-1:0]                 idx_q;
	logic                          issue_on_q;
	logic                          vld_s1;
	logic [AW-1:0]                 addr_s1;
	logic                          found_q;
	logic [apr_pkg::AGE_W-1:0]     best_age_q;
	logic [AW-1:0]                 best_idx_q;
	logic [apr_pkg::FRAME_W-1:0]   best_frame_q;
	logic [apr_pkg::COUNT_W-1:0]   frames_used_q;
	apr_pkg::res_t                 pend_q;
	apr_pkg::res_t                 out_q;
	logic                          out_valid_q;

	logic                          acc;
	logic                          in_range;
	logic [apr_pkg::COUNT_W-1:0]   limit;
	apr_pkg::entry_t               aged;
	apr_pkg::entry_t               updated;
	apr_pkg::entry_t               victim_entry;
	logic                          better;

	assign cmd.ready = (state_q == ST_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign cmd_op    = apr_pkg::op_t'(cmd.opcode);
	assign in_range  = int'(cmd.page) < PAGE_COUNT;
	assign limit     = (frame_count > apr_pkg::MAX_FRAMES) ? apr_pkg::MAX_FRAMES : frame_count;

	// aging of the entry returning from memory
	always_comb begin
		aged = mem_rdata;
		if (mem_rdata.present) begin
			aged.age        = {mem_rdata.referenced, mem_rdata.age[apr_pkg::AGE_W-1:1]};
			aged.referenced = 1'b0;
		end
	end

	assign better = !found_q || (aged.age < best_age_q);

	// reference / map / unmap update of the entry read back
	always_comb begin
		updated = mem_rdata;
		case (op_q)
			apr_pkg::OP_REF: begin
				updated.referenced = 1'b1;
			end
			apr_pkg::OP_MAP: begin
				updated.present = 1'b1;
				updated.frame   = frame_q;
			end
			apr_pkg::OP_UNMAP: begin
				updated.present    = 1'b0;
				updated.referenced = 1'b0;
			end
			default: begin
				updated = mem_rdata;
			end
		endcase
	end

	// victim after the sweep: age zeroed, referenced already cleared by aging
	always_comb begin
		victim_entry            = '0;
		victim_entry.present    = 1'b1;
		victim_entry.frame      = best_frame_q;
	end

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_re    = acc && (cmd_op != apr_pkg::OP_REQ) && in_range;
				mem_raddr = AW'(cmd.page);
			end
			ST_RMW: begin
				mem_we    = 1'b1;
				mem_waddr = page_q;
				mem_wdata = updated;
			end
			ST_SWEEP: begin
				mem_re    = issue_on_q;
				mem_we    = vld_s1 && mem_rdata.present;
				mem_waddr = addr_s1;
				mem_wdata = aged;
			end
			ST_FIX: begin
				mem_we    = found_q;
				mem_waddr = best_idx_q;
				mem_wdata = victim_entry;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// sweep read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SWEEP) && issue_on_q;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			op_q          <= apr_pkg::OP_REF;
			page_q        <= '0;
			frame_q       <= '0;
			idx_q         <= '0;
			issue_on_q    <= 1'b0;
			found_q       <= 1'b0;
			best_age_q    <= '0;
			best_idx_q    <= '0;
			best_frame_q  <= '0;
			frames_used_q <= '0;
			pend_q        <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// result taken; in ST_DONE the reload below decides instead
			if (res.ready && out_valid_q && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						op_q    <= cmd_op;
						page_q  <= AW'(cmd.page);
						frame_q <= cmd.frame;
						if (cmd_op == apr_pkg::OP_REQ) begin
							if (frames_used_q < limit) begin
								pend_q        <= '{granted_frame: frames_used_q[apr_pkg::FRAME_W-1:0],
								                   victim_page: '0, evicted: 1'b0};
								frames_used_q <= frames_used_q + apr_pkg::COUNT_W'(1);
								state_q       <= ST_DONE;
							end else begin
								idx_q      <= '0;
								issue_on_q <= 1'b1;
								found_q    <= 1'b0;
								state_q    <= ST_SWEEP;
							end
						end else if (in_range) begin
							state_q <= ST_RMW;
						end else begin
							pend_q  <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_RMW: begin
					pend_q  <= '0;
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (issue_on_q) begin
						if (idx_q == LAST) begin
							issue_on_q <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
					// running minimum, lowest index kept on ties
					if (vld_s1 && mem_rdata.present && better) begin
						found_q      <= 1'b1;
						best_age_q   <= aged.age;
						best_idx_q   <= addr_s1;
						best_frame_q <= mem_rdata.frame;
					end
					if (vld_s1 && (addr_s1 == LAST)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (found_q) begin
						pend_q <= '{granted_frame: best_frame_q,
						           victim_page: apr_pkg::PAGE_FIELD_W'(best_idx_q),
						           evicted: 1'b1};
					end else begin
						pend_q <= '{granted_frame: '0, victim_page: '0, evicted: 1'b1};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hand the result to the output register once it is free
					if (!out_valid_q || res.ready) begin
						out_q       <= pend_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.granted_frame = out_q.granted_frame;
	assign res.victim_page   = out_q.victim_page;
	assign res.evicted       = out_q.evicted;

endmodule

[bench/tb_aging_page_replacement.sv]
// tb_aging_page_replacement: self-checking bench for the aging page-replacement unit.
// Depends on apr_pkg, apr_ifs and the aging_page_replacement RTL. It runs a directed table and
// then random page-table traffic, and checks every result against its own page-table copy.
module tb_aging_page_replacement;
	import apr_pkg::*;

	localparam int PAGES           = 64;
	localparam int IDLE_LIMIT      = 4000;  // a replacement sweep plus result stalls, many times over
	localparam int ITEMS_PER_PHASE = 40;
	localparam logic [AGE_W-1:0] AGE_MSB = 32'h8000_0000;
	localparam res_t NO_GRANT = '0;

	// One row of the directed table: either a frame_count write or a command
	typedef struct packed {
		bit                 is_cfg;
		logic [COUNT_W-1:0] cfg_val;
		op_t                op;
		logic [5:0]         pg;
		logic [5:0]         fr;
		bit                 typed;
		res_t               want;
	} step_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	apr_cmd_if cmd_ch ();
	apr_res_if res_ch ();

	aging_page_replacement #(.PAGE_COUNT(PAGES)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.res     (res_ch)
	);

	always #10 clk = ~clk;

	// Bench copy of the page table and allocator
	logic [AGE_W-1:0]   age_tbl [PAGES];
	bit                 present_tbl [PAGES];
	bit                 refd_tbl [PAGES];
	logic [FRAME_W-1:0] frame_tbl [PAGES];
	logic [COUNT_W-1:0] frames_handed;
	logic [COUNT_W-1:0] frame_limit;

	res_t grants_due [$];
	int   mismatches  = 0;
	int   items_sent  = 0;
	int   burst_left  = 0;
	int   idle_cycles = 0;

	// Apply one command to the table copy and return the result it produces
	function automatic res_t compute_grant(op_t op, logic [5:0] pg, logic [5:0] fr);
		logic [COUNT_W-1:0] lim;
		logic [AGE_W-1:0]   best_age;
		int                 best;
		bit                 found;
		res_t               r;
		r        = '0;
		best_age = '0;
		best     = 0;
		found    = 1'b0;
		case (op)
			OP_REF: begin
				refd_tbl[pg] = 1'b1;
			end
			OP_MAP: begin
				present_tbl[pg] = 1'b1;
				frame_tbl[pg]   = fr;
			end
			OP_UNMAP: begin
				present_tbl[pg] = 1'b0;
				refd_tbl[pg]    = 1'b0;
			end
			default: begin
				lim = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
				if (frames_handed < lim) begin
					r.granted_frame = frames_handed[FRAME_W-1:0];
					frames_handed   = frames_handed + COUNT_W'(1);
				end else begin
					// age every present page, track the smallest (first on ties)
					for (int i = 0; i < PAGES; i++) begin
						if (present_tbl[i]) begin
							age_tbl[i] = age_tbl[i] >> 1;
							if (refd_tbl[i]) begin
								age_tbl[i] = age_tbl[i] | AGE_MSB;
								refd_tbl[i] = 1'b0;
							end
							if (!found || age_tbl[i] < best_age) begin
								found    = 1'b1;
								best     = i;
								best_age = age_tbl[i];
							end
						end
					end
					r.evicted = 1'b1;
					if (found) begin
						age_tbl[best]   = '0;
						r.granted_frame = frame_tbl[best];
						r.victim_page   = 6'(best);
					end
				end
			end
		endcase
		return r;
	endfunction

	// Result checker: each result transaction against the oldest pending grant
	always @(posedge clk) begin
		res_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (grants_due.size() == 0) begin
				$error("result transaction with no command outstanding");
				mismatches++;
			end else begin
				want = grants_due.pop_front();
				if (res_ch.granted_frame !== want.granted_frame) begin
					$error("granted_frame: expected %0d, actual %0d",
						want.granted_frame, res_ch.granted_frame);
					mismatches++;
				end
				if (res_ch.victim_page !== want.victim_page) begin
					$error("victim_page: expected %0d, actual %0d",
						want.victim_page, res_ch.victim_page);
					mismatches++;
				end
				if (res_ch.evicted !== want.evicted) begin
					$error("evicted: expected %0d, actual %0d", want.evicted, res_ch.evicted);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result-side stalls: segments of always-ready, random ready and full stall
	initial begin : rx_stall
		int seg_left;
		int mode;
		res_ch.ready = 1'b0;
		seg_left     = 0;
		mode         = 0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 2);
				seg_left = (mode == 2) ? $urandom_range(1, 30) : $urandom_range(1, 40);
			end
			seg_left--;
			case (mode)
				0: begin
					res_ch.ready = 1'b1;
				end
				1: begin
					res_ch.ready = 1'($urandom_range(0, 1));
				end
				default: begin
					res_ch.ready = 1'b0;
				end
			endcase
		end
	end

	// Read frame_count back and compare with the expected setting
	task automatic cfg_read_check();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = ADDR_FRAME_COUNT;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== PDATA_W'(frame_limit)) begin
			$error("frame_count: expected %0d, actual %0d", frame_limit, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Write frame_count (junk in the unused upper bits), then read it back
	task automatic cfg_write(input logic [COUNT_W-1:0] val);
		logic [PDATA_W-1:0] junk;
		junk = $urandom;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_FRAME_COUNT;
		pwdata  = {junk[PDATA_W-1:COUNT_W], val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		frame_limit = val;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		cfg_read_check();
	endtask

	// Drop valid and wait until every grant has come back
	task automatic quiesce();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		burst_left   = 0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Drive one command transaction in bursts with random gaps
	task automatic issue_command(input op_t op, input logic [5:0] pg, input logic [5:0] fr,
		input bit typed, input res_t typed_res, output res_t grant);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid  = 1'b1;
		cmd_ch.opcode = op;
		cmd_ch.page   = pg;
		cmd_ch.frame  = fr;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		grant = compute_grant(op, pg, fr);
		grants_due.push_back(typed ? typed_res : grant);
		items_sent++;
	endtask

	task automatic send(input op_t op, input logic [5:0] pg, input logic [5:0] fr,
		output res_t grant);
		issue_command(op, pg, fr, 1'b0, NO_GRANT, grant);
	endtask

	task automatic send_noise();
		res_t ack;
		send(op_t'(2'($urandom_range(0, 3))), 6'($urandom), 6'($urandom), ack);
	endtask

	// OS-like loop over a small working set: reference, request, evict, remap
	task automatic run_working_set();
		logic [5:0] base;
		int         span;
		int         rounds;
		res_t       g;
		res_t       ack;
		base   = 6'($urandom);
		span   = $urandom_range(2, 8);
		rounds = $urandom_range(3, 10);
		for (int k = 0; k < span; k++) begin
			if (!present_tbl[base + 6'(k)])
				send(OP_MAP, base + 6'(k), 6'($urandom), ack);
		end
		for (int r = 0; r < rounds; r++) begin
			for (int k = 0; k < span; k++) begin
				if ($urandom_range(0, 1) == 1)
					send(OP_REF, base + 6'(k), 6'($urandom), ack);
			end
			if ($urandom_range(0, 7) == 0)
				send_noise();
			send(OP_REQ, 6'($urandom), 6'($urandom), g);
			if (g.evicted)
				send(OP_UNMAP, g.victim_page, 6'($urandom), ack);
			send(OP_MAP, base + 6'($urandom_range(0, span - 1)), g.granted_frame, ack);
		end
	endtask

	// Drive one page to the maximal age while a cold page absorbs the evictions,
	// then make the saturated page the only candidate
	task automatic run_saturation();
		logic [5:0] hot;
		logic [5:0] cold;
		res_t       ack;
		for (int i = 0; i < PAGES; i++) begin
			if (present_tbl[i])
				send(OP_UNMAP, 6'(i), 6'($urandom), ack);
		end
		hot  = 6'($urandom);
		cold = hot + 6'($urandom_range(1, 63));
		send(OP_UNMAP, hot, 6'($urandom), ack);
		send(OP_UNMAP, cold, 6'($urandom), ack);
		send(OP_MAP, hot, 6'($urandom), ack);
		send(OP_MAP, cold, 6'($urandom), ack);
		repeat (AGE_W) begin
			send(OP_REF, hot, 6'($urandom), ack);
			send(OP_REQ, 6'($urandom), 6'($urandom), ack);
		end
		send(OP_UNMAP, cold, 6'($urandom), ack);
		send(OP_REF, hot, 6'($urandom), ack);
		send(OP_REQ, 6'($urandom), 6'($urandom), ack);
	endtask

	initial begin : stimulus
		step_t              plan [26];
		logic [COUNT_W-1:0] settings [6];
		int                 phase_end;
		res_t               ack;

		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.opcode = OP_REF;
		cmd_ch.page   = '0;
		cmd_ch.frame  = '0;
		for (int i = 0; i < PAGES; i++) begin
			age_tbl[i]     = '0;
			present_tbl[i] = 1'b0;
			refd_tbl[i]    = 1'b0;
			frame_tbl[i]   = '0;
		end
		frames_handed = '0;
		frame_limit   = FRAME_COUNT_RST;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// frame_count must come out of reset at its default
		cfg_read_check();

		// Directed table; typed rows carry their obvious result
		plan = '{
			'{1'b1, 7'd0, OP_REF,   6'd0,  6'd0,  1'b0, NO_GRANT},  // no free frames at all
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b1}},  // nothing present
			'{1'b0, 7'd0, OP_REF,   6'd0,  6'd63, 1'b1, NO_GRANT},  // reference before map
			'{1'b0, 7'd0, OP_MAP,   6'd63, 6'd63, 1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_MAP,   6'd0,  6'd0,  1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd63, 6'd63, 1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_UNMAP, 6'd63, 6'd63, 1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},  // single present page
			'{1'b0, 7'd0, OP_MAP,   6'd5,  6'd42, 1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_MAP,   6'd6,  6'd21, 1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_REF,   6'd6,  6'd0,  1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},  // tie goes to lowest page
			'{1'b0, 7'd0, OP_UNMAP, 6'd0,  6'd0,  1'b1, NO_GRANT},
			'{1'b0, 7'd0, OP_REF,   6'd0,  6'd63, 1'b1, NO_GRANT},  // reference while unmapped
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b1, 7'd1, OP_REF,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},  // free frame 0
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b1, 7'd3, OP_REF,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b1, '{6'd1, 6'd0, 1'b0}},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b1, '{6'd2, 6'd0, 1'b0}},
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_MAP,   6'd0,  6'd63, 1'b1, NO_GRANT},  // map keeps referenced
			'{1'b0, 7'd0, OP_REQ,   6'd0,  6'd0,  1'b0, NO_GRANT},
			'{1'b0, 7'd0, OP_UNMAP, 6'd63, 6'd0,  1'b1, NO_GRANT}
		};
		foreach (plan[n]) begin
			if (plan[n].is_cfg) begin
				quiesce();
				cfg_write(plan[n].cfg_val);
			end else begin
				issue_command(plan[n].op, plan[n].pg, plan[n].fr, plan[n].typed,
					plan[n].want, ack);
			end
		end

		// Random phases, one frame_count setting each
		settings = '{7'd0, 7'd1, 7'($urandom_range(2, 40)), 7'd64, 7'd127,
			7'($urandom_range(0, 127))};
		for (int p = 0; p < 6; p++) begin
			quiesce();
			cfg_write(settings[p]);
			if (p == 0)
				run_saturation();
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) < 7)
					run_working_set();
				else
					repeat ($urandom_range(1, 6)) send_noise();
			end
		end

		// Drain, then leave room for any stray result
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (PAGES + 16) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
